// ===== sv/srt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes of the sorted region table
// request codes, status codes, default sizes and the cell control group
// ----------------------------------------------------------------------------
package srt_pkg;

    // default table geometry
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF     = 48;
    localparam int HANDLE_BITS       = 16;

    // request codes
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_EXACT   = 2'd2;
    localparam logic [1:0] REQ_CONTAIN = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;  // latch compare flags against the request
        logic ins;  // open a slot and write the new region
        logic rem;  // close the slot of the first exact match
    } t_cell_ctl;

endpackage

// ===== sv/srt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_cell: one slot of the sorted region table
// holds one region, compares it with the request and shifts to or from
// its neighbors on insert and remove
// ----------------------------------------------------------------------------
module srt_cell #(
    parameter int ADDR_BITS   = srt_pkg::ADDR_BITS_DEF,
    parameter int HANDLE_BITS = srt_pkg::HANDLE_BITS
) (
    input  logic                   i_clk,
    input  srt_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_valid,
    // request fields
    input  logic [ADDR_BITS-1:0]   i_req_addr,
    input  logic [ADDR_BITS-1:0]   i_req_size,
    input  logic [HANDLE_BITS-1:0] i_req_handle,
    // left neighbor
    input  logic                   i_left_lt,
    input  logic [ADDR_BITS-1:0]   i_left_start,
    input  logic [ADDR_BITS-1:0]   i_left_size,
    input  logic [HANDLE_BITS-1:0] i_left_handle,
    // right neighbor
    input  logic [ADDR_BITS-1:0]   i_right_start,
    input  logic [ADDR_BITS-1:0]   i_right_size,
    input  logic [HANDLE_BITS-1:0] i_right_handle,
    // slot contents and flags
    output logic [ADDR_BITS-1:0]   o_start,
    output logic [ADDR_BITS-1:0]   o_size,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic                   o_lt,
    output logic                   o_hit,
    output logic                   o_cont
);

    logic [ADDR_BITS-1:0]   r_start;
    logic [ADDR_BITS-1:0]   r_size;
    logic [HANDLE_BITS-1:0] r_handle;
    logic                   r_lt;
    logic                   r_eq;
    logic                   r_cont;

    logic                   n_lt;
    logic                   n_eq;
    logic                   n_cont;
    logic [ADDR_BITS:0]     w_end;

    // compare against the request, end address one bit wider
    always_comb begin
        w_end  = {1'b0, r_start} + {1'b0, r_size};
        n_lt   = i_valid && (r_start < i_req_addr);
        n_eq   = i_valid && (r_start == i_req_addr);
        n_cont = i_valid && (r_start <= i_req_addr) && ({1'b0, i_req_addr} < w_end);
    end

    // flags latched in the compare cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt   <= n_lt;
            r_eq   <= n_eq;
            r_cont <= n_cont;
        end
    end

    // slot contents: keep, take new, take left or take right
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            if (i_left_lt) begin
                r_start  <= i_req_addr;
                r_size   <= i_req_size;
                r_handle <= i_req_handle;
            end else begin
                r_start  <= i_left_start;
                r_size   <= i_left_size;
                r_handle <= i_left_handle;
            end
        end else if (i_ctl.rem && !r_lt) begin
            r_start  <= i_right_start;
            r_size   <= i_right_size;
            r_handle <= i_right_handle;
        end
    end

    assign o_start  = r_start;
    assign o_size   = r_size;
    assign o_handle = r_handle;
    assign o_lt     = r_lt;
    // first equal start sits right after the last smaller one
    assign o_hit    = r_eq && i_left_lt;
    assign o_cont   = r_cont;

endmodule

// ===== sv/sorted_region_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_table_top: table of memory regions kept sorted by start
// row of slot cells with broadcast compare and one-step shift
// ----------------------------------------------------------------------------
// usage
//   a request (type, address, size, handle) is taken at a rising edge with
//   start high and busy low. types: insert, remove, find exact start, find
//   containing region. every request yields one result on o_status and the
//   found_* ports, marked by o_done for exactly one cycle; the receiver
//   cannot hold it off and needs no handshake back.
// operation
//   the request is latched when taken, then in the compare state every cell
//   compares its region with it and stores the flags, then in the execute
//   state the cells shift on insert or remove and the result is registered.
//   busy is high only in the compare state, so a new request can be taken
//   while the previous one is in its execute state.
// reset
//   synchronous, active low: the entry count goes to zero and the table is
//   empty. slot contents are not cleared; only slots below the count are
//   ever reported.
// ----------------------------------------------------------------------------
module sorted_region_table_top #(
    parameter int TABLE_ENTRIES = srt_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = srt_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_req_type,
    input  logic [ADDR_BITS-1:0]            i_address,
    input  logic [ADDR_BITS-1:0]            i_region_size,
    input  logic [srt_pkg::HANDLE_BITS-1:0] i_region_handle,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [srt_pkg::HANDLE_BITS-1:0] o_found_handle,
    output logic [ADDR_BITS-1:0]            o_found_start,
    output logic [ADDR_BITS-1:0]            o_found_size
);

    localparam int HB    = srt_pkg::HANDLE_BITS;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [1:0]          r_req;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_size;
    logic [HB-1:0]       r_handle;

    logic                r_done;
    logic [1:0]          r_status;
    logic [HB-1:0]       r_found_handle;
    logic [ADDR_BITS-1:0] r_found_start;
    logic [ADDR_BITS-1:0] r_found_size;
    logic                n_done;
    logic [1:0]          n_status;
    logic [HB-1:0]       n_found_handle;
    logic [ADDR_BITS-1:0] n_found_start;
    logic [ADDR_BITS-1:0] n_found_size;

    logic                w_accept;
    logic                w_full;
    logic                w_any_hit;
    srt_pkg::t_cell_ctl  w_ctl;

    logic [ADDR_BITS-1:0] w_start  [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] w_len    [TABLE_ENTRIES];
    logic [HB-1:0]        w_hdl    [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] w_lstart [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] w_llen   [TABLE_ENTRIES];
    logic [HB-1:0]        w_lhdl   [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] w_rstart [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] w_rlen   [TABLE_ENTRIES];
    logic [HB-1:0]        w_rhdl   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] w_valid;
    logic [TABLE_ENTRIES-1:0] w_lt;
    logic [TABLE_ENTRIES-1:0] w_left_lt;
    logic [TABLE_ENTRIES-1:0] w_hit;
    logic [TABLE_ENTRIES-1:0] w_cont;
    logic [TABLE_ENTRIES-1:0] w_cont_first;
    logic [TABLE_ENTRIES-1:0] w_sel;

    assign busy     = (r_state == S_CMP);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(TABLE_ENTRIES));
    assign w_any_hit = |w_hit;

    // cell control from the sequencer state
    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = (r_state == S_EXEC) && (r_req == srt_pkg::REQ_INSERT) && !w_full;
        w_ctl.rem = (r_state == S_EXEC) && (r_req == srt_pkg::REQ_REMOVE) && w_any_hit;
    end

    // row of cells with neighbor links
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        assign w_valid[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_left_lt[g] = 1'b1;
            assign w_lstart[g]  = w_start[g];
            assign w_llen[g]    = w_len[g];
            assign w_lhdl[g]    = w_hdl[g];
        end else begin : g_mid
            assign w_left_lt[g] = w_lt[g-1];
            assign w_lstart[g]  = w_start[g-1];
            assign w_llen[g]    = w_len[g-1];
            assign w_lhdl[g]    = w_hdl[g-1];
        end

        if (g == TABLE_ENTRIES - 1) begin : g_last
            assign w_rstart[g] = w_start[g];
            assign w_rlen[g]   = w_len[g];
            assign w_rhdl[g]   = w_hdl[g];
        end else begin : g_inner
            assign w_rstart[g] = w_start[g+1];
            assign w_rlen[g]   = w_len[g+1];
            assign w_rhdl[g]   = w_hdl[g+1];
        end

        srt_cell #(
            .ADDR_BITS   (ADDR_BITS),
            .HANDLE_BITS (HB)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_valid        (w_valid[g]),
            .i_req_addr     (r_addr),
            .i_req_size     (r_size),
            .i_req_handle   (r_handle),
            .i_left_lt      (w_left_lt[g]),
            .i_left_start   (w_lstart[g]),
            .i_left_size    (w_llen[g]),
            .i_left_handle  (w_lhdl[g]),
            .i_right_start  (w_rstart[g]),
            .i_right_size   (w_rlen[g]),
            .i_right_handle (w_rhdl[g]),
            .o_start        (w_start[g]),
            .o_size         (w_len[g]),
            .o_handle       (w_hdl[g]),
            .o_lt           (w_lt[g]),
            .o_hit          (w_hit[g]),
            .o_cont         (w_cont[g])
        );
    end

    // lowest containing slot, isolated by a single add
    assign w_cont_first = w_cont & (~w_cont + TABLE_ENTRIES'(1));
    assign w_sel = (r_req == srt_pkg::REQ_CONTAIN) ? w_cont_first : w_hit;

    // result and count for the execute cycle
    always_comb begin
        n_found_handle = '0;
        n_found_start  = '0;
        n_found_size   = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            n_found_handle = n_found_handle | (w_hdl[k] & {HB{w_sel[k]}});
            n_found_start  = n_found_start | (w_start[k] & {ADDR_BITS{w_sel[k]}});
            n_found_size   = n_found_size | (w_len[k] & {ADDR_BITS{w_sel[k]}});
        end
        n_done   = (r_state == S_EXEC);
        n_count  = r_count;
        n_status = srt_pkg::ST_OK;
        unique case (r_req)
            srt_pkg::REQ_INSERT: begin
                n_found_handle = '0;
                n_found_start  = '0;
                n_found_size   = '0;
                n_status = w_full ? srt_pkg::ST_FULL : srt_pkg::ST_OK;
                if (w_ctl.ins) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            srt_pkg::REQ_REMOVE: begin
                n_status = w_any_hit ? srt_pkg::ST_OK : srt_pkg::ST_MISS;
                if (w_ctl.rem) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            srt_pkg::REQ_EXACT: begin
                n_status = w_any_hit ? srt_pkg::ST_OK : srt_pkg::ST_MISS;
            end
            srt_pkg::REQ_CONTAIN: begin
                n_status = (|w_cont) ? srt_pkg::ST_OK : srt_pkg::ST_MISS;
            end
            default: begin
                n_status = srt_pkg::ST_MISS;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        if (w_accept) begin
            n_state = S_CMP;
        end else if (r_state == S_CMP) begin
            n_state = S_EXEC;
        end else begin
            n_state = S_IDLE;
        end
    end

    // state, count and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req    <= i_req_type;
            r_addr   <= i_address;
            r_size   <= i_region_size;
            r_handle <= i_region_handle;
        end
        if (r_state == S_EXEC) begin
            r_status       <= n_status;
            r_found_handle <= n_found_handle;
            r_found_start  <= n_found_start;
            r_found_size   <= n_found_size;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_found_handle = r_found_handle;
    assign o_found_start  = r_found_start;
    assign o_found_size   = r_found_size;

    // count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    // a result follows exactly one execute cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_done)
        else $error("result missing after execute");

    // insert into a full table leaves the count alone
    a_full_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_req == srt_pkg::REQ_INSERT && w_full) |=> $stable(r_count))
        else $error("full insert changed the table");

    // at most one slot is selected for a result
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(w_sel))
        else $error("more than one slot selected");

endmodule
